// ----- design/assert_macros.svh -----
// Assertion helper macros shared by the capture-to-mark/space RTL.
// Each macro assumes clk_i and rst_ni exist in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ICMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ICMS_ASSERT_NEVER(lbl, cond, msg) \
  `ICMS_ASSERT(lbl, !(cond), msg)

`endif

// ----- design/icms_pkg.sv -----
// Shared types and constants for the IR capture to mark/space converter.
// No dependencies; used by icms_div and ir_capture_to_mark_space.
package icms_pkg;

  // Divider operand widths
  localparam int unsigned NumW = 32;
  localparam int unsigned DenW = 16;

  // Input beat kinds carried on tuser
  localparam logic ACT_INTERVAL = 1'b0;
  localparam logic ACT_FINISH   = 1'b1;

  // Interval classification limits (48 MHz ticks)
  localparam logic [31:0] PULSE_LO  = 32'd700;
  localparam logic [31:0] PULSE_HI  = 32'd1429;
  localparam logic [31:0] LONG_GAP  = 32'd9600;

  // Conversion constants
  localparam logic [31:0] STOP_MARK   = 32'd100000;
  localparam logic [19:0] US_PER_SEC  = 20'd1000000;
  localparam logic [31:0] HALF_SEC_US = 32'd500000;
  localparam logic [15:0] TICKS_PER_US = 16'd48;
  localparam logic [9:0]  US_PER_MS   = 10'd1000;
  localparam logic [15:0] CARRIER_HZ_RST = 16'd38000;

  // ticks/48 as (ticks * TICK_RECIP) >> TICK_SHIFT, exact for 16-bit ticks
  localparam logic [15:0] TICK_RECIP = 16'd43691;
  localparam int unsigned TICK_SHIFT = 21;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [NumW-1:0]   dividend;
    logic [DenW-1:0]   divisor;
  } div_req_t;

  // Status and result from the shared divider
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [NumW-1:0]   quotient;
  } div_rsp_t;

endpackage

// ----- design/icms_div.sv -----
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
// Depends on icms_pkg (request/response structs) and assert_macros.svh.
`include "assert_macros.svh"

module icms_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  icms_pkg::div_req_t req_i,
  output icms_pkg::div_rsp_t rsp_o
);
  import icms_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [NumW-1:0]   quo_q, quo_d;
  logic [DenW-1:0]   rem_q, rem_d;
  logic [DenW-1:0]   den_q, den_d;
  logic [DenW:0]     rem_sh;
  logic              ge;

  // One restoring step: shift in the next dividend bit, try to subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[NumW-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (busy_q) begin
      quo_d = {quo_q[NumW-2:0], ge};
      rem_d = ge ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `ICMS_ASSERT_NEVER(a_no_start_busy, req_i.start && busy_q, "divider started while busy")
  `ICMS_ASSERT(a_done_pulse, done_q |=> !done_q, "divider done held longer than one cycle")
  `ICMS_ASSERT(a_done_after_busy, done_q |-> $past(busy_q), "divider done without a run")

endmodule

// ----- design/ir_capture_to_mark_space.sv -----
// Top level: converts captured IR edge intervals into mark/space table entries.
// Depends on icms_pkg, icms_div and assert_macros.svh.
//
//   channel   dir  beat contents (low bit first)
//   s_axis    in   tdata[31:0] raw_interval, tuser[0] action
//   m_axis    out  tdata[7:0] slot_index, tdata[39:8] duration_us, tlast is_last
//   cfg       in   cfg_wdata_i[15:0] carrier_hz, written when cfg_we_i is high
//
// Carrier pulses, ignored intervals and long gaps on a full table leave the
// sequencer idle. A long gap first forms the measured gap (ticks/48 by reciprocal
// multiply), then makes two passes through the shared serial divider (half
// period, burst length) and emits one beat per cycle while the output is free.
// A finish item makes one divider pass with a pending burst, none without.
// Each emit state holds until the one-beat output register is free; the next
// item is taken while the last beat waits. Reset clears counters, sequencer
// and output valid; carrier_hz returns to 38000.
`include "assert_macros.svh"

module ir_capture_to_mark_space #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] raw_interval
  input  logic        s_axis_tuser_i,   // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] slot_index, [39:8] duration_us
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import icms_pkg::*;

  localparam int unsigned EntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [EntW-1:0] DEPTH_E   = EntW'(TABLE_DEPTH);
  localparam logic [EntW-1:0] LAST_SLOT = EntW'(TABLE_DEPTH - 1);

  // Sequencer codes
  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_MEAS       = 3'd1;
  localparam logic [2:0] S_HALF_DIV   = 3'd2;
  localparam logic [2:0] S_BURST_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT_BURST = 3'd4;
  localparam logic [2:0] S_EMIT_GAP   = 3'd5;
  localparam logic [2:0] S_EMIT_STOP  = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [EntW-1:0] entry_q, entry_d;
  logic [11:0]     pulse_q, pulse_d;
  logic [15:0]     hz_q;
  logic            fin_q, fin_d;
  logic [15:0]     ms_q, ms_d;
  logic [15:0]     ticks_q, ticks_d;
  logic [31:0]     prod_q, prod_d;
  logic [26:0]     meas_q, meas_d;
  logic [31:0]     gap_q, gap_d;
  logic [31:0]     burst_q, burst_d;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_slot_q, out_slot_d;
  logic [31:0]     out_dur_q, out_dur_d;
  logic            out_last_q, out_last_d;

  logic            accept;
  logic            out_free;
  logic            is_pulse;
  logic            is_long;
  logic [31:0]     burst_num;
  logic [31:0]     tick_prod;
  logic [10:0]     tick_us;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  icms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign is_pulse = (s_axis_tdata_i > PULSE_LO) && (s_axis_tdata_i < PULSE_HI);
  assign is_long  = (s_axis_tdata_i > LONG_GAP);

  // Burst numerator: pulse count times one million, at most 4095000000
  assign burst_num = {20'd0, pulse_q} * {12'd0, US_PER_SEC};

  // Ticks to microseconds by reciprocal multiply
  assign tick_prod = {16'd0, ticks_q} * {16'd0, TICK_RECIP};
  assign tick_us   = tick_prod[TICK_SHIFT +: 11];

  // Sequencer: classify the beat, drive the divider, emit table entries
  always_comb begin
    state_d     = state_q;
    entry_d     = entry_q;
    pulse_d     = pulse_q;
    fin_d       = fin_q;
    ms_d        = ms_q;
    ticks_d     = ticks_q;
    prod_d      = prod_q;
    meas_d      = meas_q;
    gap_d       = gap_q;
    burst_d     = burst_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_slot_d  = out_slot_q;
    out_dur_d   = out_dur_q;
    out_last_d  = out_last_q;
    div_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          prod_d  = burst_num;
          ms_d    = s_axis_tdata_i[31:16];
          ticks_d = s_axis_tdata_i[15:0];
          if (s_axis_tuser_i == ACT_FINISH) begin
            // Finish: flush a pending burst, then the stop marker
            fin_d   = 1'b1;
            pulse_d = '0;
            if ((entry_q < DEPTH_E) && (pulse_q != '0)) begin
              div_req.start    = 1'b1;
              div_req.dividend = burst_num;
              div_req.divisor  = hz_q;
              state_d          = S_BURST_DIV;
            end else begin
              state_d = S_EMIT_STOP;
            end
          end else if (is_pulse) begin
            // Count a carrier pulse, saturating
            if (pulse_q != '1) begin
              pulse_d = pulse_q + 12'd1;
            end
          end else if (is_long) begin
            fin_d   = 1'b0;
            pulse_d = '0;
            if (entry_q < LAST_SLOT) begin
              state_d = S_MEAS;
            end
          end
        end
      end
      S_MEAS: begin
        meas_d = 27'(ms_q) * 27'(US_PER_MS) + 27'(tick_us);
        div_req.start    = 1'b1;
        div_req.dividend = HALF_SEC_US;
        div_req.divisor  = hz_q;
        state_d          = S_HALF_DIV;
      end
      S_HALF_DIV: begin
        if (div_rsp.done) begin
          gap_d = ({5'd0, meas_q} > div_rsp.quotient) ?
                  ({5'd0, meas_q} - div_rsp.quotient) : 32'd0;
          div_req.start    = 1'b1;
          div_req.dividend = prod_q;
          div_req.divisor  = hz_q;
          state_d          = S_BURST_DIV;
        end
      end
      S_BURST_DIV: begin
        if (div_rsp.done) begin
          burst_d = div_rsp.quotient;
          state_d = S_EMIT_BURST;
        end
      end
      S_EMIT_BURST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_slot_d  = 8'(entry_q);
          out_dur_d   = burst_q;
          out_last_d  = 1'b0;
          entry_d     = entry_q + EntW'(1);
          state_d     = fin_q ? S_EMIT_STOP : S_EMIT_GAP;
        end
      end
      S_EMIT_GAP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_slot_d  = 8'(entry_q);
          out_dur_d   = gap_q;
          out_last_d  = 1'b1;
          entry_d     = entry_q + EntW'(1);
          state_d     = S_IDLE;
        end
      end
      S_EMIT_STOP: begin
        if (out_free) begin
          // Overwrite the last slot when the table is full
          out_valid_d = 1'b1;
          out_slot_d  = (entry_q < DEPTH_E) ? 8'(entry_q) : 8'(LAST_SLOT);
          out_dur_d   = STOP_MARK;
          out_last_d  = 1'b1;
          entry_d     = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      entry_q     <= '0;
      pulse_q     <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      hz_q        <= CARRIER_HZ_RST;
    end else begin
      state_q     <= state_d;
      entry_q     <= entry_d;
      pulse_q     <= pulse_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        hz_q <= cfg_wdata_i;
      end
    end
  end

  // Working values and output payload
  always_ff @(posedge clk_i) begin
    ms_q       <= ms_d;
    ticks_q    <= ticks_d;
    prod_q     <= prod_d;
    meas_q     <= meas_d;
    gap_q      <= gap_d;
    burst_q    <= burst_d;
    out_slot_q <= out_slot_d;
    out_dur_q  <= out_dur_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_dur_q, out_slot_q};
  assign m_axis_tlast_o  = out_last_q;

  `ICMS_ASSERT_NEVER(a_ready_div_idle, s_axis_tready_o && div_rsp.busy, "ready while divider runs")
  `ICMS_ASSERT(a_mid_beat_followed, (out_valid_q && !out_last_q) |-> (state_q == S_EMIT_GAP || state_q == S_EMIT_STOP), "non-final beat without its follow-up")
  `ICMS_ASSERT(a_entry_range, entry_q <= DEPTH_E, "entry count beyond table depth")

endmodule

// ----- tb/testbench.sv -----
// Testbench for ir_capture_to_mark_space: drives interval and finish beats,
// predicts every table entry in a local model, and checks each output beat.
// Depends on icms_pkg and the ir_capture_to_mark_space RTL.
module testbench;
  import icms_pkg::*;

  localparam int unsigned DEPTH         = 256;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned MAX_REPORTS   = 50;

  // One learned table entry as it leaves the block
  typedef struct packed {
    logic [7:0]  slot;
    logic [31:0] duration;
    logic        last;
  } entry_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;   // [31:0] raw_interval
  logic        s_axis_tuser_i  = 1'b0; // [0] action
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;         // [7:0] slot_index, [39:8] duration_us
  logic        m_axis_tlast_o;
  logic        cfg_we_i        = 1'b0;
  logic [15:0] cfg_wdata_i     = '0;

  // Local copy of the converter state
  logic [15:0] model_hz;
  logic [8:0]  model_entries;
  logic [11:0] model_pulses;

  entry_t      pending_entries_q[$];
  int unsigned counted_items;
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  ir_capture_to_mark_space #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Quotient clipped to 32 bits; a zero divisor gives all ones
  function automatic logic [31:0] div_saturate(logic [63:0] num, logic [15:0] den);
    logic [63:0] q;
    if (den == '0) return '1;
    q = num / 64'(den);
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic void push_entry(logic [31:0] dur);
    pending_entries_q.push_back('{slot: model_entries[7:0], duration: dur, last: 1'b0});
    model_entries++;
  endfunction

  // Advance the local state by one accepted beat and queue its table entries
  function automatic void convert_interval(bit action, logic [31:0] raw);
    int unsigned base;
    logic [31:0] meas;
    logic [31:0] half;
    logic [31:0] gap;
    base = pending_entries_q.size();
    if (action == ACT_INTERVAL) begin
      if (raw > PULSE_LO && raw < PULSE_HI) begin
        if (model_pulses != 12'hFFF) model_pulses++;
        counted_items++;
      end else if (raw > LONG_GAP) begin
        if (model_entries < DEPTH - 1) begin
          meas = 32'(raw[31:16]) * 32'(US_PER_MS) + 32'(raw[15:0]) / 32'(TICKS_PER_US);
          half = div_saturate(64'(HALF_SEC_US), model_hz);
          gap  = (meas > half) ? meas - half : '0;
          push_entry(div_saturate(64'(model_pulses) * 64'(US_PER_SEC), model_hz));
          push_entry(gap);
        end
        model_pulses = '0;
        counted_items++;
      end
    end else begin
      if (model_entries < DEPTH && model_pulses != '0)
        push_entry(div_saturate(64'(model_pulses) * 64'(US_PER_SEC), model_hz));
      // A full table gets its stop marker on the last slot
      if (model_entries < DEPTH) begin
        push_entry(STOP_MARK);
      end else begin
        pending_entries_q.push_back('{slot: 8'(DEPTH - 1), duration: STOP_MARK, last: 1'b0});
      end
      model_entries = '0;
      model_pulses  = '0;
      counted_items++;
    end
    if (pending_entries_q.size() > base)
      pending_entries_q[pending_entries_q.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // Send one beat; entered and left at a falling edge
  task automatic send_item(bit action, logic [31:0] raw);
    s_axis_tvalid_i = 1'b0;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tuser_i  = action;
    s_axis_tdata_i  = raw;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    convert_interval(action, raw);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every queued entry, then let the divider settle
  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (pending_entries_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_carrier(logic [15:0] hz);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = hz;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    model_hz = hz;
  endtask

  function automatic logic [31:0] pulse_word();
    return $urandom_range(PULSE_HI - 1, PULSE_LO + 1);
  endfunction

  function automatic logic [31:0] gap_word();
    case ($urandom_range(3))
      0:       return $urandom_range(20000, LONG_GAP + 1);
      1:       return {16'($urandom_range(50)), 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  // Intervals that are neither carrier pulses nor long gaps
  function automatic logic [31:0] other_word();
    case ($urandom_range(4))
      0:       return $urandom_range(PULSE_LO);
      1:       return $urandom_range(LONG_GAP, PULSE_HI);
      2:       return PULSE_LO;
      3:       return PULSE_HI;
      default: return LONG_GAP;
    endcase
  endfunction

  function automatic logic [15:0] pick_carrier();
    case ($urandom_range(4))
      0:       return 16'd30000;
      1:       return 16'd60000;
      default: return 16'($urandom_range(60000, 30000));
    endcase
  endfunction

  // Field boundaries, empty finish, leftover burst and ignored intervals
  task automatic test_basic();
    send_item(ACT_FINISH, 32'h0);
    send_item(ACT_INTERVAL, PULSE_LO);
    send_item(ACT_INTERVAL, PULSE_LO + 1);
    send_item(ACT_INTERVAL, PULSE_HI - 1);
    send_item(ACT_INTERVAL, PULSE_HI);
    send_item(ACT_INTERVAL, 32'h0);
    send_item(ACT_INTERVAL, LONG_GAP);
    send_item(ACT_INTERVAL, LONG_GAP + 1);
    send_item(ACT_INTERVAL, 32'hFFFF_FFFF);
    send_item(ACT_INTERVAL, 32'h0001_0000);
    send_item(ACT_INTERVAL, 32'd1000);
    send_item(ACT_FINISH, 32'hFFFF_FFFF);
    send_item(ACT_INTERVAL, 32'd1000);
    send_item(ACT_INTERVAL, LONG_GAP + 1);
    send_item(ACT_FINISH, 32'h0);
  endtask

  // Zero, tiny and extreme carrier settings; tiny ones underflow the gap
  task automatic test_carrier_extremes();
    logic [15:0] hz_list[5];
    hz_list = '{16'd0, 16'd1, 16'hFFFF, 16'd30000, 16'd60000};
    foreach (hz_list[i]) begin
      set_carrier(hz_list[i]);
      send_item(ACT_INTERVAL, 32'd1000);
      send_item(ACT_INTERVAL, 32'h0000_FFFF);
      send_item(ACT_INTERVAL, PULSE_LO + 1);
      send_item(ACT_FINISH, 32'h0);
    end
  endtask

  // Long bursts at the smallest carrier give the largest burst values
  task automatic test_large_burst();
    set_carrier(16'd1);
    repeat (120) send_item(ACT_INTERVAL, pulse_word());
    send_item(ACT_INTERVAL, gap_word());
    repeat (5) send_item(ACT_INTERVAL, pulse_word());
    send_item(ACT_FINISH, $urandom());
  endtask

  // Fill the table to one pair short, then completely with overflow gaps
  task automatic test_table_full();
    set_carrier(CARRIER_HZ_RST);
    repeat ((DEPTH - 2) / 2) begin
      send_item(ACT_INTERVAL, pulse_word());
      send_item(ACT_INTERVAL, gap_word());
    end
    send_item(ACT_INTERVAL, pulse_word());
    send_item(ACT_FINISH, $urandom());
    repeat (DEPTH / 2 + 2) begin
      send_item(ACT_INTERVAL, pulse_word());
      send_item(ACT_INTERVAL, gap_word());
    end
    send_item(ACT_INTERVAL, pulse_word());
    send_item(ACT_FINISH, $urandom());
  endtask

  // Well-formed capture: bursts of pulses, long gaps, a finish, some noise
  task automatic send_frame();
    int unsigned bursts;
    int unsigned pulses;
    bursts = ($urandom_range(7) == 0) ? $urandom_range(132, 122) : $urandom_range(10);
    repeat (bursts) begin
      if ($urandom_range(7) == 0) pulses = 0;
      else if (bursts > 100)      pulses = $urandom_range(3, 1);
      else                        pulses = $urandom_range(40, 1);
      repeat (pulses) begin
        if ($urandom_range(19) == 0) send_item(ACT_INTERVAL, other_word());
        send_item(ACT_INTERVAL, pulse_word());
      end
      send_item(ACT_INTERVAL, gap_word());
    end
    if ($urandom_range(1) == 0)
      repeat ($urandom_range(20, 1)) send_item(ACT_INTERVAL, pulse_word());
    // Leave some frames open so the next one runs on
    if ($urandom_range(15) != 0) send_item(ACT_FINISH, $urandom());
  endtask

  task automatic test_random_frames(int unsigned target);
    int unsigned stop_at;
    stop_at = counted_items + target;
    while (counted_items < stop_at) begin
      if ($urandom_range(3) == 0) set_carrier(pick_carrier());
      if ($urandom_range(9) == 0) begin
        repeat (8) send_item($urandom_range(1), $urandom());
      end else begin
        send_frame();
      end
    end
  endtask

  // Receiver stalls
  always @(negedge clk_i) begin
    m_axis_tready_i = ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each output beat with the oldest queued entry
  always @(posedge clk_i) begin
    entry_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_entries_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat slot %0d duration %0d",
                                  m_axis_tdata_o[7:0], m_axis_tdata_o[39:8]));
      end else begin
        want = pending_entries_q.pop_front();
        if (m_axis_tdata_o[7:0] !== want.slot)
          report_mismatch($sformatf("slot got %0d expected %0d",
                                    m_axis_tdata_o[7:0], want.slot));
        if (m_axis_tdata_o[39:8] !== want.duration)
          report_mismatch($sformatf("slot %0d duration got %0d expected %0d",
                                    want.slot, m_axis_tdata_o[39:8], want.duration));
        if (m_axis_tlast_o !== want.last)
          report_mismatch($sformatf("slot %0d tlast got %b expected %b",
                                    want.slot, m_axis_tlast_o, want.last));
      end
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    model_hz       = CARRIER_HZ_RST;
    model_entries  = '0;
    model_pulses   = '0;
    counted_items  = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    send_idle_pct  = 17;
    recv_idle_pct  = 88;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic();
    test_carrier_extremes();
    test_large_burst();
    test_table_full();
    test_random_frames(180);

    send_idle_pct = 88;
    recv_idle_pct = 17;
    test_random_frames(180);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(180);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/icms_pkg.sv
design/icms_div.sv
design/ir_capture_to_mark_space.sv
tb/testbench.sv
